[design/afts_pkg.sv]
package afts_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COURANT_SQ   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REFL_GAIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_POS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_POS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_AMP   = 3'd7;

	// register reset values
	localparam logic [5:0]  RST_DIM        = 6'd32;
	localparam logic [14:0] RST_COURANT_SQ = 15'd21845;
	localparam logic [16:0] RST_REFL_GAIN  = 17'd65536;
	localparam logic [31:0] RST_SOURCE_AMP = 32'd16777216;

	// Q1.12 corner weight
	localparam int WGT_W = 13;
	localparam logic [WGT_W-1:0] WGT_ONE = 13'd4096;

	// datapath operations
	typedef logic [3:0] op_t;
	localparam op_t OP_NOP     = 4'd0;
	localparam op_t OP_CLR     = 4'd1;
	localparam op_t OP_SCLR    = 4'd2;
	localparam op_t OP_ACC_CLR = 4'd3;
	localparam op_t OP_ACC_ADD = 4'd4;
	localparam op_t OP_LAP     = 4'd5;
	localparam op_t OP_LMUL    = 4'd6;
	localparam op_t OP_LWR     = 4'd7;
	localparam op_t OP_GMUL    = 4'd8;
	localparam op_t OP_GWR     = 4'd9;
	localparam op_t OP_W0      = 4'd10;
	localparam op_t OP_W1      = 4'd11;
	localparam op_t OP_W2      = 4'd12;
	localparam op_t OP_INJ     = 4'd13;
	localparam op_t OP_RACC    = 4'd14;
	localparam op_t OP_SFIN    = 4'd15;

	typedef struct packed {
		op_t              op;
		logic             use_amp;
		logic             swap;
		logic [WGT_W-1:0] wx;
		logic [WGT_W-1:0] wy;
		logic [WGT_W-1:0] wz;
	} dp_cmd_t;

endpackage

[design/afts_ram.sv]
module afts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/afts_ctrl.sv]
module afts_ctrl #(
	parameter int MAX_DIM = 32,
	parameter int AW      = $clog2(MAX_DIM * MAX_DIM * MAX_DIM)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              start_run,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic [5:0]        grid_width,
	input  logic [5:0]        grid_height,
	input  logic [5:0]        grid_depth,
	input  logic [59:0]       source_position,
	input  logic [59:0]       receiver_position,
	output afts_pkg::dp_cmd_t cmd,
	output logic [AW-1:0]     raddr,
	output logic [AW-1:0]     waddr
);

	import afts_pkg::*;

	localparam int CW    = $clog2(MAX_DIM);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int SLICE = MAX_DIM * MAX_DIM;
	localparam int CELLS = SLICE * MAX_DIM;

	localparam logic [2:0] S_RCLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_CLR  = 3'd2;
	localparam logic [2:0] S_INT  = 3'd3;
	localparam logic [2:0] S_BND  = 3'd4;
	localparam logic [2:0] S_SRC  = 3'd5;
	localparam logic [2:0] S_RCV  = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	// interior cell steps: six neighbor reads, center read, then math
	localparam logic [3:0] STEP_FIRST = 4'd0;
	localparam logic [3:0] STEP_CTR   = 4'd6;
	localparam logic [3:0] STEP_LAP   = 4'd7;
	localparam logic [3:0] STEP_MUL   = 4'd8;
	localparam logic [3:0] STEP_WR    = 4'd9;
	// boundary and corner steps
	localparam logic [3:0] STEP_B_MUL = 4'd1;
	localparam logic [3:0] STEP_B_WR  = 4'd2;
	localparam logic [3:0] STEP_C_W1  = 4'd1;
	localparam logic [3:0] STEP_C_W2  = 4'd2;
	localparam logic [3:0] STEP_C_WR  = 4'd3;

	logic [2:0]    state_q, state_d;
	logic [3:0]    step_q, step_d;
	logic [CW-1:0] x_q, y_q, z_q, x_d, y_d, z_d;
	logic [2:0]    k_q, k_d;
	logic [AW-1:0] cnt_q, cnt_d;
	logic          start_q, start_d;
	logic          out_valid_q, out_valid_d;

	logic [DW-1:0] dim_w, dim_h, dim_d;
	logic [31:0]   w32, h32, d32, x32, y32, z32;
	logic [31:0]   i32, n32, j32, c32, ra32, wa32;
	logic [31:0]   dimv [3];
	logic [31:0]   cc [3];
	logic [WGT_W-1:0] wgt [3];
	logic [59:0]   pos;
	logic [19:0]   coord;
	logic [31:0]   ip, lo, hi, fr, jx, jy, jz;
	logic          is_int, ix_end, iy_end, iz_end, bx_end, by_end, bz_end;

	function automatic logic [DW-1:0] use_dim(input logic [5:0] v);
		logic [31:0] t;
		t = 32'(v);
		if (t < 32'd3) begin
			t = 32'd3;
		end else if (t > 32'(MAX_DIM)) begin
			t = 32'(MAX_DIM);
		end
		return t[DW-1:0];
	endfunction

	assign dim_w = use_dim(grid_width);
	assign dim_h = use_dim(grid_height);
	assign dim_d = use_dim(grid_depth);

	// cell addresses for the current scan position
	always_comb begin
		w32 = 32'(dim_w);
		h32 = 32'(dim_h);
		d32 = 32'(dim_d);
		x32 = 32'(x_q);
		y32 = 32'(y_q);
		z32 = 32'(z_q);
		i32 = x32 + 32'(MAX_DIM) * y32 + 32'(SLICE) * z32;
		case (step_q)
			4'd0:    n32 = i32 - 32'd1;
			4'd1:    n32 = i32 + 32'd1;
			4'd2:    n32 = i32 - 32'(MAX_DIM);
			4'd3:    n32 = i32 + 32'(MAX_DIM);
			4'd4:    n32 = i32 - 32'(SLICE);
			4'd5:    n32 = i32 + 32'(SLICE);
			default: n32 = i32;
		endcase
		// clamp a boundary cell onto its interior neighbor
		jx = (x32 < 32'd1) ? 32'd1 : ((x32 > w32 - 32'd2) ? w32 - 32'd2 : x32);
		jy = (y32 < 32'd1) ? 32'd1 : ((y32 > h32 - 32'd2) ? h32 - 32'd2 : y32);
		jz = (z32 < 32'd1) ? 32'd1 : ((z32 > d32 - 32'd2) ? d32 - 32'd2 : z32);
		j32 = jx + 32'(MAX_DIM) * jy + 32'(SLICE) * jz;
		is_int = (x32 != 32'd0) && (x32 != w32 - 32'd1) && (y32 != 32'd0)
			&& (y32 != h32 - 32'd1) && (z32 != 32'd0) && (z32 != d32 - 32'd1);
		ix_end = (x32 == w32 - 32'd2);
		iy_end = (y32 == h32 - 32'd2);
		iz_end = (z32 == d32 - 32'd2);
		bx_end = (x32 == w32 - 32'd1);
		by_end = (y32 == h32 - 32'd1);
		bz_end = (z32 == d32 - 32'd1);
	end

	// trilinear corner k of the source or receiver position
	always_comb begin
		pos = (state_q == S_SRC) ? source_position : receiver_position;
		dimv[0] = w32;
		dimv[1] = h32;
		dimv[2] = d32;
		for (int a = 0; a < 3; a++) begin
			coord = pos[20*a +: 20];
			ip = 32'(coord[19:12]);
			lo = (ip < dimv[a] - 32'd1) ? ip : dimv[a] - 32'd1;
			hi = (lo + 32'd1 < dimv[a]) ? lo + 32'd1 : dimv[a] - 32'd1;
			fr = (hi == lo) ? 32'd0 : 32'(coord[11:0]);
			if (k_q[a]) begin
				cc[a]  = hi;
				wgt[a] = fr[WGT_W-1:0];
			end else begin
				cc[a]  = lo;
				wgt[a] = WGT_ONE - fr[WGT_W-1:0];
			end
		end
		c32 = cc[0] + 32'(MAX_DIM) * cc[1] + 32'(SLICE) * cc[2];
	end

	// sequence one tick
	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		x_d         = x_q;
		y_d         = y_q;
		z_d         = z_q;
		k_d         = k_q;
		cnt_d       = cnt_q;
		start_d     = start_q;
		out_valid_d = out_valid_q & ~out_ready;
		in_ready    = 1'b0;
		ra32        = i32;
		wa32        = i32;
		cmd         = '0;
		cmd.wx      = wgt[0];
		cmd.wy      = wgt[1];
		cmd.wz      = wgt[2];
		unique case (state_q) inside
			S_RCLR, S_CLR: begin
				cmd.op = OP_CLR;
				wa32 = 32'(cnt_q);
				if (cnt_q == AW'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = (state_q == S_RCLR) ? S_IDLE : S_INT;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_SCLR;
					start_d = start_run;
					x_d     = CW'(1);
					y_d     = CW'(1);
					z_d     = CW'(1);
					step_d  = STEP_FIRST;
					state_d = start_run ? S_CLR : S_INT;
				end
			end
			S_INT: begin
				ra32 = n32;
				case (step_q) inside
					STEP_FIRST: cmd.op = OP_ACC_CLR;
					[4'd1:STEP_CTR]: cmd.op = OP_ACC_ADD;
					STEP_LAP: cmd.op = OP_LAP;
					STEP_MUL: cmd.op = OP_LMUL;
					default: cmd.op = OP_LWR;
				endcase
				if (step_q == STEP_WR) begin
					step_d = STEP_FIRST;
					if (!ix_end) begin
						x_d = x_q + CW'(1);
					end else begin
						x_d = CW'(1);
						if (!iy_end) begin
							y_d = y_q + CW'(1);
						end else begin
							y_d = CW'(1);
							if (!iz_end) begin
								z_d = z_q + CW'(1);
							end else begin
								x_d     = '0;
								y_d     = '0;
								z_d     = '0;
								state_d = S_BND;
							end
						end
					end
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			S_BND: begin
				ra32 = j32;
				case (step_q)
					STEP_B_MUL: cmd.op = OP_GMUL;
					STEP_B_WR:  cmd.op = OP_GWR;
					default:    cmd.op = OP_NOP;
				endcase
				if (is_int || step_q == STEP_B_WR) begin
					step_d = STEP_FIRST;
					if (!bx_end) begin
						x_d = x_q + CW'(1);
					end else begin
						x_d = '0;
						if (!by_end) begin
							y_d = y_q + CW'(1);
						end else begin
							y_d = '0;
							if (!bz_end) begin
								z_d = z_q + CW'(1);
							end else begin
								k_d     = '0;
								state_d = start_q ? S_SRC : S_RCV;
							end
						end
					end
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			S_SRC, S_RCV: begin
				ra32 = c32;
				wa32 = c32;
				cmd.use_amp = (state_q == S_SRC);
				case (step_q)
					STEP_C_W1: cmd.op = OP_W1;
					STEP_C_W2: cmd.op = OP_W2;
					STEP_C_WR: cmd.op = (state_q == S_SRC) ? OP_INJ : OP_RACC;
					default:   cmd.op = OP_W0;
				endcase
				if (step_q == STEP_C_WR) begin
					step_d = STEP_FIRST;
					k_d    = k_q + 3'd1;
					if (k_q == 3'd7) begin
						state_d = (state_q == S_SRC) ? S_RCV : S_FIN;
					end
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = OP_SFIN;
					cmd.swap    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RCLR;
			step_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			x_q         <= x_d;
			y_q         <= y_d;
			z_q         <= z_d;
			k_q         <= k_d;
			cnt_q       <= cnt_d;
			start_q     <= start_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign raddr     = ra32[AW-1:0];
	assign waddr     = wa32[AW-1:0];
	assign out_valid = out_valid_q;

endmodule

[design/afts_dp.sv]
module afts_dp #(
	parameter int MAX_DIM     = 32,
	parameter int SAMPLE_BITS = 32,
	parameter int AW          = $clog2(MAX_DIM * MAX_DIM * MAX_DIM)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  afts_pkg::dp_cmd_t  cmd,
	input  logic [AW-1:0]      raddr,
	input  logic [AW-1:0]      waddr,
	input  logic [14:0]        coupling_sq,
	input  logic [16:0]        reflection_gain,
	input  logic signed [31:0] source_amplitude,
	output logic signed [31:0] receiver_sample,
	output logic               saturated
);

	import afts_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int VW    = (SB > 32) ? SB : 32;
	localparam int OB    = (SB < 32) ? SB : 32;
	localparam int LW    = SB + 4;
	localparam int PW    = LW + 17;
	localparam int MW1   = VW + 26;
	localparam int MW2   = VW + 16;
	localparam int SAW   = VW + 4;
	localparam int XW    = PW + 2;

	localparam logic signed [XW-1:0] SB_MAX = {{(XW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [XW-1:0] SB_MIN = {{(XW-SB+1){1'b1}}, {(SB-1){1'b0}}};
	localparam logic signed [XW-1:0] OB_MAX = {{(XW-OB+1){1'b0}}, {(OB-1){1'b1}}};
	localparam logic signed [XW-1:0] OB_MIN = {{(XW-OB+1){1'b1}}, {(OB-1){1'b0}}};
	localparam logic signed [PW-1:0]  HALF16 = PW'(32768);
	localparam logic signed [MW1-1:0] HALF24 = MW1'(8388608);
	localparam logic signed [MW2-1:0] HALF12 = MW2'(2048);

	logic                  sel_q;
	logic                  flag_q;
	logic signed [SB+2:0]  acc_q;
	logic signed [LW-1:0]  lap_q;
	logic signed [SB-1:0]  c_q, p_q, base_q;
	logic signed [PW-1:0]  prod_q;
	logic [24:0]           wxy_q;
	logic signed [MW1-1:0] m1_q;
	logic signed [MW2-1:0] m2_q;
	logic signed [SAW-1:0] sacc_q;
	logic signed [OB-1:0]  sample_q;
	logic                  sat_q;

	logic [SB-1:0]         rd_a, rd_b;
	logic signed [SB-1:0]  cur_rd, nxt_rd;
	logic signed [LW-1:0]  cx;
	logic signed [VW-1:0]  v;
	logic signed [MW1-1:0] r1;
	logic signed [MW2-1:0] wv;
	logic signed [XW-1:0]  sx;
	logic signed [SB-1:0]  wval;
	logic signed [OB-1:0]  oval;
	logic                  sb_ovf, ob_ovf, wr, we_a, we_b;
	logic [SB-1:0]         wdata;

	// pressure banks: one holds the present step, the other the prior and next
	afts_ram #(.WIDTH(SB), .DEPTH(CELLS)) u_bank_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_a)
	);

	afts_ram #(.WIDTH(SB), .DEPTH(CELLS)) u_bank_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_b)
	);

	assign cur_rd = sel_q ? $signed(rd_b) : $signed(rd_a);
	assign nxt_rd = sel_q ? $signed(rd_a) : $signed(rd_b);

	// operands and saturation of the value to be written
	always_comb begin
		cx = LW'(cur_rd);
		v  = cmd.use_amp ? VW'(source_amplitude) : VW'(nxt_rd);
		r1 = m1_q >>> 24;
		wv = m2_q >>> 12;
		case (cmd.op)
			OP_LWR:  sx = (XW'(c_q) <<< 1) - XW'(p_q) + XW'(prod_q >>> 16);
			OP_GWR:  sx = XW'(prod_q >>> 16);
			OP_INJ:  sx = XW'(base_q) + XW'(wv);
			default: sx = XW'(sacc_q);
		endcase
		sb_ovf = (sx > SB_MAX) || (sx < SB_MIN);
		ob_ovf = (sx > OB_MAX) || (sx < OB_MIN);
		if (sx > SB_MAX) begin
			wval = SB_MAX[SB-1:0];
		end else if (sx < SB_MIN) begin
			wval = SB_MIN[SB-1:0];
		end else begin
			wval = sx[SB-1:0];
		end
		if (sx > OB_MAX) begin
			oval = OB_MAX[OB-1:0];
		end else if (sx < OB_MIN) begin
			oval = OB_MIN[OB-1:0];
		end else begin
			oval = sx[OB-1:0];
		end
		wr    = (cmd.op == OP_LWR) || (cmd.op == OP_GWR) || (cmd.op == OP_INJ);
		we_a  = (cmd.op == OP_CLR) || (wr && sel_q);
		we_b  = (cmd.op == OP_CLR) || (wr && !sel_q);
		wdata = (cmd.op == OP_CLR) ? '0 : wval;
	end

	// hold bank select and saturation flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q  <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			if (cmd.swap) begin
				sel_q <= ~sel_q;
			end
			if (cmd.op == OP_SCLR) begin
				flag_q <= 1'b0;
			end else if (wr && sb_ovf) begin
				flag_q <= 1'b1;
			end
		end
	end

	// arithmetic stages
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SCLR: begin
				sacc_q <= '0;
			end
			OP_ACC_CLR: begin
				acc_q <= '0;
			end
			OP_ACC_ADD: begin
				acc_q <= acc_q + (SB+3)'(cur_rd);
			end
			OP_LAP: begin
				lap_q <= LW'(acc_q) - ((cx <<< 2) + (cx <<< 1));
				c_q   <= cur_rd;
				p_q   <= nxt_rd;
			end
			OP_LMUL: begin
				prod_q <= PW'(lap_q) * PW'($signed({1'b0, coupling_sq})) + HALF16;
			end
			OP_GMUL: begin
				prod_q <= PW'(nxt_rd) * PW'($signed({1'b0, reflection_gain})) + HALF16;
			end
			OP_W0: begin
				wxy_q <= 25'(cmd.wx) * 25'(cmd.wy);
			end
			OP_W1: begin
				m1_q   <= MW1'(v) * MW1'($signed({1'b0, wxy_q})) + HALF24;
				base_q <= nxt_rd;
			end
			OP_W2: begin
				m2_q <= MW2'(r1) * MW2'($signed({1'b0, cmd.wz})) + HALF12;
			end
			OP_RACC: begin
				sacc_q <= sacc_q + SAW'(wv);
			end
			OP_SFIN: begin
				sample_q <= oval;
				sat_q    <= flag_q | ob_ovf;
			end
			default: begin
			end
		endcase
	end

	assign receiver_sample = 32'(sample_q);
	assign saturated       = sat_q;

endmodule

[design/acoustic_fdtd_time_step.sv]
// Per tick: a pass over the interior cells (seven serial reads of the
// present-step bank through its single read port, then the update math),
// then a pass over every cell of the box with a gain and a write step per
// boundary cell, then corner passes (source only on a run start), plus accept and finish.
// A run start first clears both banks. One tick at a time.
// Reset: asynchronous; a clearing pass over all cells holds in_ready low.
module acoustic_fdtd_time_step #(
	parameter int MAX_DIM     = 32,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               start_run,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [31:0]                 receiver_sample,
	output logic                               saturated,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [afts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [afts_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import afts_pkg::*;

	localparam int AW = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);

	logic [5:0]  grid_width_q, grid_height_q, grid_depth_q;
	logic [14:0] courant_sq_q;
	logic [16:0] refl_gain_q;
	logic [59:0] source_pos_q, receiver_pos_q;
	logic [31:0] source_amp_q;

	dp_cmd_t       cmd;
	logic [AW-1:0] raddr, waddr;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= RST_DIM;
			grid_height_q  <= RST_DIM;
			grid_depth_q   <= RST_DIM;
			courant_sq_q   <= RST_COURANT_SQ;
			refl_gain_q    <= RST_REFL_GAIN;
			source_pos_q   <= '0;
			receiver_pos_q <= '0;
			source_amp_q   <= RST_SOURCE_AMP;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:   grid_width_q   <= cfg_data[5:0];
				REG_GRID_HEIGHT:  grid_height_q  <= cfg_data[5:0];
				REG_GRID_DEPTH:   grid_depth_q   <= cfg_data[5:0];
				REG_COURANT_SQ:   courant_sq_q   <= cfg_data[14:0];
				REG_REFL_GAIN:    refl_gain_q    <= cfg_data[16:0];
				REG_SOURCE_POS:   source_pos_q   <= cfg_data[59:0];
				REG_RECEIVER_POS: receiver_pos_q <= cfg_data[59:0];
				REG_SOURCE_AMP:   source_amp_q   <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	afts_ctrl #(.MAX_DIM(MAX_DIM), .AW(AW)) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.start_run        (start_run),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.grid_width       (grid_width_q),
		.grid_height      (grid_height_q),
		.grid_depth       (grid_depth_q),
		.source_position  (source_pos_q),
		.receiver_position(receiver_pos_q),
		.cmd              (cmd),
		.raddr            (raddr),
		.waddr            (waddr)
	);

	afts_dp #(.MAX_DIM(MAX_DIM), .SAMPLE_BITS(SAMPLE_BITS), .AW(AW)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.raddr           (raddr),
		.waddr           (waddr),
		.coupling_sq     (courant_sq_q),
		.reflection_gain (refl_gain_q),
		.source_amplitude($signed(source_amp_q)),
		.receiver_sample (receiver_sample),
		.saturated       (saturated)
	);

endmodule

[design/afts_chk.sv]
module afts_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] receiver_sample,
	input logic        saturated
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(receiver_sample)
			&& $stable(saturated)))
		else $error("result changed while stalled");

	// one tick in flight: drop ready after a request
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while a tick runs");

	// a tick never finishes in the cycle after its request
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind acoustic_fdtd_time_step afts_chk u_afts_chk (.*);
